[src/gha_pkg.sv]
// Package for the generational handle allocator.
// Holds the slot sizing constants, the action and status codes and the field widths.
// No dependencies.
`default_nettype none

package gha_pkg;

   // Slot store sizing
   localparam int MAX_SLOTS = 1024;
   localparam int SLOT_W    = $clog2(MAX_SLOTS);
   localparam int CNT_W     = $clog2(MAX_SLOTS + 1);

   // Field widths
   localparam int ACT_W    = 2;
   localparam int ID_W     = 16;
   localparam int GEN_W    = 16;
   localparam int STATUS_W = 2;
   localparam int TOTAL_W  = 32;
   localparam int CAP_W    = 11;

   // Slot word: live flag above the generation
   localparam int SLOT_WORD_W = GEN_W + 1;

   localparam logic [GEN_W-1:0] GEN_FIRST = GEN_W'(1);

   // Request actions
   localparam logic [ACT_W-1:0] ACT_CREATE   = 2'd0;
   localparam logic [ACT_W-1:0] ACT_DESTROY  = 2'd1;
   localparam logic [ACT_W-1:0] ACT_VALIDATE = 2'd2;
   localparam logic [ACT_W-1:0] ACT_CLEAR    = 2'd3;

   // Response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOFREE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_STALE  = 2'd2;

   // Stream payload widths
   localparam int REQ_DATA_W = ID_W + GEN_W;
   localparam int RSP_BITS   = ID_W + GEN_W + 1 + CNT_W + CNT_W + TOTAL_W;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

endpackage : gha_pkg

`default_nettype wire

[src/gha_ram.sv]
// Generic single write port, single read port RAM with a registered read.
// Used for the slot table and the free stack. No dependencies.
`default_nettype none

module gha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule : gha_ram

`default_nettype wire

[src/generational_handle_allocator_top.sv]
// Top level of the generational handle allocator.
// Depends on gha_pkg and gha_ram (slot table and free stack).
//
// Usage:
// The req_ stream carries one command per transaction: create, destroy,
// validate or clear all. Every command yields exactly one rsp_ transaction
// with status, the created handle, the prior validity of the given handle
// and the live, peak and created counters.
// Commands run one at a time on a small sequencer around the two RAMs.
// A create pops the free stack, then does a slot read-modify-write.
// Destroy and validate check the slot word read at acceptance. Clear all
// reads one slot per cycle up to the capacity, write-back behind it.
// req_tready is high only while no command is in progress.
// The response sits in an output register; the next command is accepted
// while it waits, and a command finishing while rsp_tready stays low
// holds until the register frees up.
// Reset and every csr_ write run an initialization pass over every slot
// (generation 1, not live, stack entry i = i) with no command accepted.
// csr_ writes are always taken; capacity above 1024 saturates to 1024.
`default_nettype none

module generational_handle_allocator_top
   import gha_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Command stream
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // tdata: handle_index [15:0], handle_generation [31:16]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // tuser: action [1:0]
   input  wire logic [ACT_W-1:0]      req_tuser,
   // Response stream
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // tdata: out_id [15:0], out_generation [31:16], handle_valid [32],
   //        live_count [43:33], peak_count [54:44], total_created [86:55]
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // tuser: status [1:0]
   output logic [STATUS_W-1:0]        rsp_tuser,
   // Capacity register write
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CAP_W-1:0]      csr_wdata
);

   typedef enum logic [5:0] {
      ST_INIT  = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_LOOK  = 6'b000100,
      ST_CLAIM = 6'b001000,
      ST_CLEAR = 6'b010000,
      ST_RESP  = 6'b100000
   } state_type;

   // Saturate a capacity write to the slot count
   function automatic logic [CNT_W-1:0] sat_cap(input logic [CAP_W-1:0] value);
      logic [CNT_W-1:0] result;
      if (32'(value) > MAX_SLOTS) begin
         result = CNT_W'(MAX_SLOTS);
      end else begin
         result = CNT_W'(value);
      end
      return result;
   endfunction

   // Advance a generation, skipping zero
   function automatic logic [GEN_W-1:0] bump_gen(input logic [GEN_W-1:0] gen);
      logic [GEN_W-1:0] result;
      result = gen + GEN_W'(1);
      if (result == '0) begin
         result = GEN_FIRST;
      end
      return result;
   endfunction

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cap_ff, cap_in;
   logic [CNT_W-1:0]  fc_ff, fc_in;
   logic [CNT_W-1:0]  live_ff, live_in;
   logic [CNT_W-1:0]  peak_ff, peak_in;
   logic [TOTAL_W-1:0] created_ff, created_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic              pend_ff, pend_in;
   logic [SLOT_W-1:0] paddr_ff, paddr_in;
   logic [ACT_W-1:0]  act_ff, act_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic [GEN_W-1:0]  gen_ff, gen_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              hval_ff, hval_in;
   logic [STATUS_W-1:0] rstat_ff, rstat_in;
   logic [ID_W-1:0]   rid_ff, rid_in;
   logic [GEN_W-1:0]  rgen_ff, rgen_in;
   logic              rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic [STATUS_W-1:0] rsp_tuser_ff, rsp_tuser_in;

   logic                   slot_we;
   logic [SLOT_W-1:0]      slot_waddr, slot_raddr;
   logic [SLOT_WORD_W-1:0] slot_wdata, slot_rdata;
   logic                   stk_we;
   logic [SLOT_W-1:0]      stk_waddr, stk_raddr, stk_wdata, stk_rdata;

   logic [CNT_W-1:0] fc_dec;
   logic             handle_ok;
   logic             out_free;

   assign fc_dec = fc_ff - CNT_W'(1);

   // Handle check against the slot word read for id_ff
   assign handle_ok = (id_ff < {{(ID_W-CNT_W){1'b0}}, cap_ff}) && (gen_ff != '0)
                      && slot_rdata[GEN_W] && (slot_rdata[GEN_W-1:0] == gen_ff);

   assign out_free = !rsp_tvalid_ff || rsp_tready;

   // Sequencer and datapath
   always_comb begin
      state_in      = state_ff;
      cap_in        = cap_ff;
      fc_in         = fc_ff;
      live_in       = live_ff;
      peak_in       = peak_ff;
      created_in    = created_ff;
      idx_in        = idx_ff;
      pend_in       = pend_ff;
      paddr_in      = paddr_ff;
      act_in        = act_ff;
      id_in         = id_ff;
      gen_in        = gen_ff;
      slot_in       = slot_ff;
      hval_in       = hval_ff;
      rstat_in      = rstat_ff;
      rid_in        = rid_ff;
      rgen_in       = rgen_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;

      slot_we    = 1'b0;
      slot_waddr = '0;
      slot_wdata = '0;
      slot_raddr = req_tdata[SLOT_W-1:0];
      stk_we     = 1'b0;
      stk_waddr  = '0;
      stk_wdata  = '0;
      stk_raddr  = fc_dec[SLOT_W-1:0];

      case (state_ff)
         ST_INIT: begin
            // Sweep every slot back to its initial contents
            slot_we    = 1'b1;
            slot_waddr = idx_ff[SLOT_W-1:0];
            slot_wdata = {1'b0, GEN_FIRST};
            stk_we     = 1'b1;
            stk_waddr  = idx_ff[SLOT_W-1:0];
            stk_wdata  = idx_ff[SLOT_W-1:0];
            idx_in     = idx_ff + CNT_W'(1);
            if (idx_ff == CNT_W'(MAX_SLOTS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            // Take a command; slot and stack top reads are launched here
            if (req_tvalid) begin
               act_in   = req_tuser;
               id_in    = req_tdata[ID_W-1:0];
               gen_in   = req_tdata[REQ_DATA_W-1:ID_W];
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            hval_in  = handle_ok;
            rid_in   = '0;
            rgen_in  = '0;
            rstat_in = STATUS_OK;
            state_in = ST_RESP;
            case (act_ff)
               ACT_CREATE: begin
                  // Pop the free stack and read the popped slot
                  if (fc_ff == '0 || {1'b0, stk_rdata} >= cap_ff) begin
                     rstat_in = STATUS_NOFREE;
                  end else begin
                     fc_in      = fc_dec;
                     slot_in    = stk_rdata;
                     slot_raddr = stk_rdata;
                     state_in   = ST_CLAIM;
                  end
               end
               ACT_DESTROY: begin
                  // Free the slot, advance its generation, push it
                  if (handle_ok) begin
                     slot_we    = 1'b1;
                     slot_waddr = id_ff[SLOT_W-1:0];
                     slot_wdata = {1'b0, bump_gen(slot_rdata[GEN_W-1:0])};
                     if (fc_ff < cap_ff) begin
                        stk_we    = 1'b1;
                        stk_waddr = fc_ff[SLOT_W-1:0];
                        stk_wdata = id_ff[SLOT_W-1:0];
                        fc_in     = fc_ff + CNT_W'(1);
                     end
                     if (live_ff != '0) begin
                        live_in = live_ff - CNT_W'(1);
                     end
                  end else begin
                     rstat_in = STATUS_STALE;
                  end
               end
               ACT_VALIDATE: begin
                  rstat_in = handle_ok ? STATUS_OK : STATUS_STALE;
               end
               ACT_CLEAR: begin
                  idx_in   = '0;
                  pend_in  = 1'b0;
                  state_in = ST_CLEAR;
               end
               default: begin
                  rstat_in = STATUS_OK;
               end
            endcase
         end
         ST_CLAIM: begin
            // Mark the popped slot live and report its handle
            slot_we    = 1'b1;
            slot_waddr = slot_ff;
            slot_wdata = {1'b1, slot_rdata[GEN_W-1:0]};
            live_in    = live_ff + CNT_W'(1);
            if (live_in > peak_ff) begin
               peak_in = live_in;
            end
            created_in = created_ff + TOTAL_W'(1);
            rid_in     = ID_W'(slot_ff);
            rgen_in    = slot_rdata[GEN_W-1:0];
            rstat_in   = STATUS_OK;
            state_in   = ST_RESP;
         end
         ST_CLEAR: begin
            // Release the slot whose word just arrived
            if (pend_ff && slot_rdata[GEN_W]) begin
               slot_we    = 1'b1;
               slot_waddr = paddr_ff;
               slot_wdata = {1'b0, bump_gen(slot_rdata[GEN_W-1:0])};
               if (fc_ff < cap_ff) begin
                  stk_we    = 1'b1;
                  stk_waddr = fc_ff[SLOT_W-1:0];
                  stk_wdata = paddr_ff;
                  fc_in     = fc_ff + CNT_W'(1);
               end
            end
            // Issue the next slot read, or finish
            slot_raddr = idx_ff[SLOT_W-1:0];
            if (idx_ff < cap_ff) begin
               pend_in  = 1'b1;
               paddr_in = idx_ff[SLOT_W-1:0];
               idx_in   = idx_ff + CNT_W'(1);
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  live_in  = '0;
                  state_in = ST_RESP;
               end
            end
         end
         ST_RESP: begin
            // Load the output register once it is free
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tuser_in  = rstat_ff;
               rsp_tdata_in  = RSP_DATA_W'({created_ff, peak_ff, live_ff, hval_ff,
                                            rgen_ff, rid_ff});
               state_in      = ST_IDLE;
            end
         end
         default: begin
            idx_in   = '0;
            state_in = ST_INIT;
         end
      endcase

      // Capacity write: reinitialize the store
      if (csr_valid) begin
         cap_in     = sat_cap(csr_wdata);
         fc_in      = sat_cap(csr_wdata);
         live_in    = '0;
         peak_in    = '0;
         created_in = '0;
         idx_in     = '0;
         pend_in    = 1'b0;
         state_in   = ST_INIT;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         cap_ff        <= sat_cap(CAP_W'(1024));
         fc_ff         <= sat_cap(CAP_W'(1024));
         live_ff       <= '0;
         peak_ff       <= '0;
         created_ff    <= '0;
         idx_ff        <= '0;
         pend_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cap_ff        <= cap_in;
         fc_ff         <= fc_in;
         live_ff       <= live_in;
         peak_ff       <= peak_in;
         created_ff    <= created_in;
         idx_ff        <= idx_in;
         pend_ff       <= pend_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      paddr_ff     <= paddr_in;
      act_ff       <= act_in;
      id_ff        <= id_in;
      gen_ff       <= gen_in;
      slot_ff      <= slot_in;
      hval_ff      <= hval_in;
      rstat_ff     <= rstat_in;
      rid_ff       <= rid_in;
      rgen_ff      <= rgen_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   // Slot table: live flag and generation per slot
   gha_ram #(
      .WIDTH (SLOT_WORD_W),
      .DEPTH (MAX_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (slot_waddr),
      .wr_data (slot_wdata),
      .rd_addr (slot_raddr),
      .rd_data (slot_rdata)
   );

   // Free stack of slot indexes
   gha_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (MAX_SLOTS)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata),
      .rd_addr (stk_raddr),
      .rd_data (stk_rdata)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule : generational_handle_allocator_top

`default_nettype wire

[sim/generational_handle_allocator_top_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for generational_handle_allocator_top.
// Runs a directed table and randomized phases, checked by an in-bench slot store
// predictor or a row's expected value. Depends on gha_pkg and the allocator RTL.

module generational_handle_allocator_top_tb;
   import gha_pkg::*;

   localparam int CAP_AT_RESET = 1024;
   localparam int ITEMS_PER_PHASE = 150;
   localparam int SETTLE_CYCLES = 16;

   // Response field offsets inside rsp_tdata
   localparam int HV_LSB    = ID_W + GEN_W;
   localparam int LIVE_LSB  = HV_LSB + 1;
   localparam int PEAK_LSB  = LIVE_LSB + CNT_W;
   localparam int TOTAL_LSB = PEAK_LSB + CNT_W;

   typedef struct {
      logic [ACT_W-1:0] act;
      logic [ID_W-1:0]  id;
      logic [GEN_W-1:0] gen;
   } alloc_cmd_type;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     out_id;
      logic [GEN_W-1:0]    out_gen;
      logic                hvalid;
      logic [CNT_W-1:0]    live;
      logic [CNT_W-1:0]    peak;
      logic [TOTAL_W-1:0]  total;
   } alloc_rsp_type;

   typedef enum logic {ROW_CAP, ROW_CMD} row_kind_type;

   typedef struct {
      row_kind_type     kind;
      logic [CAP_W-1:0] cap;
      alloc_cmd_type    cmd;
      bit               has_want;
      alloc_rsp_type    want;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [ACT_W-1:0]      req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]   rsp_tuser;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CAP_W-1:0]      csr_wdata = '0;

   // Predicted slot store
   logic [GEN_W-1:0]  slot_gen [MAX_SLOTS];
   logic              slot_live [MAX_SLOTS];
   logic [SLOT_W-1:0] free_slots [MAX_SLOTS];
   int                slot_limit;
   int                free_depth;
   int                live_now;
   int                live_peak;
   logic [TOTAL_W-1:0] create_total;

   alloc_rsp_type pending_rsp [$];
   alloc_rsp_type no_rsp;
   stim_row_type  stim_table [$];

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int mismatch_count = 0;
   int rsp_seen = 0;
   int nofree_seen = 0;
   int stale_seen = 0;
   int cap_writes = 0;
   int cmd_count [4] = '{0, 0, 0, 0};

   generational_handle_allocator_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Rebuild the store as a capacity write does
   function automatic void reinit_store(input int cap);
      slot_limit = (cap > MAX_SLOTS) ? MAX_SLOTS : cap;
      for (int i = 0; i < MAX_SLOTS; i++) begin
         slot_gen[i]   = GEN_FIRST;
         slot_live[i]  = 1'b0;
         free_slots[i] = SLOT_W'(i);
      end
      free_depth   = slot_limit;
      live_now     = 0;
      live_peak    = 0;
      create_total = '0;
   endfunction

   function automatic logic handle_live(input logic [ID_W-1:0] id, input logic [GEN_W-1:0] gen);
      if (int'(id) >= slot_limit || gen == '0)
         return 1'b0;
      return slot_live[id] && slot_gen[id] == gen;
   endfunction

   // Free a slot, advance its generation past zero, push it back
   function automatic void retire_slot(input int unsigned slot);
      logic [GEN_W-1:0] g;
      slot_live[slot] = 1'b0;
      g = slot_gen[slot] + GEN_W'(1);
      if (g == '0)
         g = GEN_FIRST;
      slot_gen[slot] = g;
      if (free_depth < slot_limit) begin
         free_slots[free_depth] = SLOT_W'(slot);
         free_depth++;
      end
   endfunction

   // Apply one command to the predicted store and return its response
   function automatic alloc_rsp_type step_allocator(input alloc_cmd_type c);
      alloc_rsp_type r;
      logic          ok;
      int unsigned   slot;
      r.status  = STATUS_OK;
      r.out_id  = '0;
      r.out_gen = '0;
      ok = handle_live(c.id, c.gen);
      case (c.act)
         ACT_CREATE: begin
            if (free_depth == 0 || free_depth > slot_limit) begin
               r.status = STATUS_NOFREE;
            end else begin
               free_depth--;
               slot = free_slots[free_depth];
               if (slot >= slot_limit) begin
                  r.status = STATUS_NOFREE;
                  free_depth++;
               end else begin
                  slot_live[slot] = 1'b1;
                  live_now++;
                  if (live_now > live_peak)
                     live_peak = live_now;
                  create_total++;
                  r.out_id  = ID_W'(slot);
                  r.out_gen = slot_gen[slot];
               end
            end
         end
         ACT_DESTROY: begin
            if (ok) begin
               retire_slot(c.id);
               if (live_now > 0)
                  live_now--;
            end else begin
               r.status = STATUS_STALE;
            end
         end
         ACT_VALIDATE: begin
            r.status = ok ? STATUS_OK : STATUS_STALE;
         end
         ACT_CLEAR: begin
            for (int i = 0; i < slot_limit; i++)
               if (slot_live[i])
                  retire_slot(i);
            live_now = 0;
         end
         default: begin
            r.status = STATUS_OK;
         end
      endcase
      r.hvalid = ok;
      r.live   = CNT_W'(live_now);
      r.peak   = CNT_W'(live_peak);
      r.total  = create_total;
      return r;
   endfunction

   function automatic alloc_rsp_type rsp_of(input logic [STATUS_W-1:0] status, input int out_id,
                                            input int out_gen, input logic hvalid, input int live,
                                            input int peak, input int total);
      alloc_rsp_type r;
      r.status  = status;
      r.out_id  = ID_W'(out_id);
      r.out_gen = GEN_W'(out_gen);
      r.hvalid  = hvalid;
      r.live    = CNT_W'(live);
      r.peak    = CNT_W'(peak);
      r.total   = TOTAL_W'(total);
      return r;
   endfunction

   function automatic stim_row_type cmd_row(input logic [ACT_W-1:0] act, input int id,
                                            input int gen);
      stim_row_type row;
      row.kind     = ROW_CMD;
      row.cap      = '0;
      row.cmd.act  = act;
      row.cmd.id   = ID_W'(id);
      row.cmd.gen  = GEN_W'(gen);
      row.has_want = 1'b0;
      row.want     = no_rsp;
      return row;
   endfunction

   function automatic stim_row_type checked_row(input logic [ACT_W-1:0] act, input int id,
                                                input int gen, input alloc_rsp_type want);
      stim_row_type row;
      row = cmd_row(act, id, gen);
      row.has_want = 1'b1;
      row.want     = want;
      return row;
   endfunction

   function automatic stim_row_type cap_row(input int cap);
      stim_row_type row;
      row = cmd_row(ACT_CREATE, 0, 0);
      row.kind = ROW_CAP;
      row.cap  = CAP_W'(cap);
      return row;
   endfunction

   // Mostly well-formed traffic on live handles, with near misses and noise
   function automatic alloc_cmd_type random_cmd();
      alloc_cmd_type c;
      int unsigned   roll;
      int unsigned   slot;
      roll = $urandom_range(0, 99);
      slot = (slot_limit == 0) ? 0 : $urandom_range(0, slot_limit - 1);
      for (int k = 0; k < 8 && slot_limit != 0 && !slot_live[slot]; k++)
         slot = $urandom_range(0, slot_limit - 1);
      c.id  = ID_W'(slot);
      c.gen = slot_gen[slot];
      if (roll < 40) begin
         c.act = ACT_CREATE;
         if ($urandom_range(0, 1) != 0) begin
            c.id  = ID_W'($urandom_range(0, 65535));
            c.gen = GEN_W'($urandom_range(0, 65535));
         end
      end else if (roll < 70) begin
         c.act = ACT_DESTROY;
      end else if (roll < 80) begin
         c.act = ACT_VALIDATE;
      end else if (roll < 88) begin
         c.act = ($urandom_range(0, 1) != 0) ? ACT_DESTROY : ACT_VALIDATE;
         case ($urandom_range(0, 2))
            0: c.gen = c.gen ^ (GEN_W'(1) << $urandom_range(0, GEN_W - 1));
            1: c.gen = c.gen - GEN_W'(1);
            default: c.id = ID_W'(slot + slot_limit + $urandom_range(0, 60000));
         endcase
      end else if (roll < 97) begin
         c.act = ACT_W'($urandom_range(0, 3));
         c.id  = ID_W'($urandom_range(0, 65535));
         c.gen = GEN_W'($urandom_range(0, 65535));
      end else begin
         c.act = ACT_CLEAR;
      end
      return c;
   endfunction

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      if (mismatch_count < 200)
         $display("%0t ns: response %0d %s: got %0h, expected %0h",
                  $time, rsp_seen, what, got, want);
      mismatch_count++;
   endtask

   // Offer one command, predict its response at acceptance
   task automatic send_command(input alloc_cmd_type c, input bit has_want,
                               input alloc_rsp_type want);
      alloc_rsp_type predicted;
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {c.gen, c.id};
      req_tuser  <= c.act;
      do @(posedge clock); while (!req_tready);
      predicted = step_allocator(c);
      pending_rsp.push_back(has_want ? want : predicted);
      cmd_count[c.act]++;
   endtask

   // Hold the command stream until every response is back
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      wait_idle();
      csr_valid <= 1'b1;
      csr_wdata <= cap;
      do @(posedge clock); while (!csr_ready);
      reinit_store(int'(cap));
      cap_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Randomize response backpressure
   always @(negedge clock)
      rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);

   // Check each response transaction against the oldest prediction
   always @(posedge clock) begin : rsp_check
      alloc_rsp_type got;
      alloc_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_seen++;
         got.status  = rsp_tuser;
         got.out_id  = rsp_tdata[ID_W-1:0];
         got.out_gen = rsp_tdata[ID_W +: GEN_W];
         got.hvalid  = rsp_tdata[HV_LSB];
         got.live    = rsp_tdata[LIVE_LSB +: CNT_W];
         got.peak    = rsp_tdata[PEAK_LSB +: CNT_W];
         got.total   = rsp_tdata[TOTAL_LSB +: TOTAL_W];
         if (got.status == STATUS_NOFREE)
            nofree_seen++;
         if (got.status == STATUS_STALE)
            stale_seen++;
         if (pending_rsp.size() == 0) begin
            report_mismatch("arrived with no command pending", got.status, 0);
         end else begin
            want = pending_rsp.pop_front();
            if (got.status !== want.status)
               report_mismatch("status", got.status, want.status);
            if (got.out_id !== want.out_id)
               report_mismatch("out_id", got.out_id, want.out_id);
            if (got.out_gen !== want.out_gen)
               report_mismatch("out_generation", got.out_gen, want.out_gen);
            if (got.hvalid !== want.hvalid)
               report_mismatch("handle_valid", got.hvalid, want.hvalid);
            if (got.live !== want.live)
               report_mismatch("live_count", got.live, want.live);
            if (got.peak !== want.peak)
               report_mismatch("peak_count", got.peak, want.peak);
            if (got.total !== want.total)
               report_mismatch("total_created", got.total, want.total);
         end
      end
   end

   initial begin
      int phase_cap [6];
      int phase_idle [6];
      int phase_stall [6];

      reinit_store(CAP_AT_RESET);
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table: reset state, handle checks, saturation, zero and one slot
      stim_table.push_back(checked_row(ACT_CREATE, 0, 0, rsp_of(STATUS_OK, 1023, 1, 0, 1, 1, 1)));
      stim_table.push_back(checked_row(ACT_VALIDATE, 1023, 1, rsp_of(STATUS_OK, 0, 0, 1, 1, 1, 1)));
      stim_table.push_back(checked_row(ACT_VALIDATE, 1023, 0,
                                       rsp_of(STATUS_STALE, 0, 0, 0, 1, 1, 1)));
      stim_table.push_back(checked_row(ACT_VALIDATE, 1024, 1,
                                       rsp_of(STATUS_STALE, 0, 0, 0, 1, 1, 1)));
      stim_table.push_back(checked_row(ACT_VALIDATE, 65535, 65535,
                                       rsp_of(STATUS_STALE, 0, 0, 0, 1, 1, 1)));
      stim_table.push_back(checked_row(ACT_DESTROY, 1022, 1,
                                       rsp_of(STATUS_STALE, 0, 0, 0, 1, 1, 1)));
      stim_table.push_back(checked_row(ACT_DESTROY, 1023, 2,
                                       rsp_of(STATUS_STALE, 0, 0, 0, 1, 1, 1)));
      stim_table.push_back(checked_row(ACT_DESTROY, 1023, 1, rsp_of(STATUS_OK, 0, 0, 1, 0, 1, 1)));
      stim_table.push_back(checked_row(ACT_DESTROY, 1023, 1,
                                       rsp_of(STATUS_STALE, 0, 0, 0, 0, 1, 1)));
      stim_table.push_back(checked_row(ACT_CREATE, 1023, 1,
                                       rsp_of(STATUS_OK, 1023, 2, 0, 1, 1, 2)));
      stim_table.push_back(cmd_row(ACT_CREATE, 1023, 2));
      stim_table.push_back(cmd_row(ACT_CREATE, 0, 0));
      stim_table.push_back(checked_row(ACT_CLEAR, 65535, 0, rsp_of(STATUS_OK, 0, 0, 0, 0, 3, 4)));
      stim_table.push_back(cmd_row(ACT_VALIDATE, 1023, 2));
      stim_table.push_back(cap_row(2047));
      stim_table.push_back(checked_row(ACT_CREATE, 65535, 65535,
                                       rsp_of(STATUS_OK, 1023, 1, 0, 1, 1, 1)));
      stim_table.push_back(cap_row(0));
      stim_table.push_back(checked_row(ACT_CREATE, 0, 1, rsp_of(STATUS_NOFREE, 0, 0, 0, 0, 0, 0)));
      stim_table.push_back(checked_row(ACT_VALIDATE, 0, 1,
                                       rsp_of(STATUS_STALE, 0, 0, 0, 0, 0, 0)));
      stim_table.push_back(checked_row(ACT_DESTROY, 0, 1, rsp_of(STATUS_STALE, 0, 0, 0, 0, 0, 0)));
      stim_table.push_back(checked_row(ACT_CLEAR, 0, 1, rsp_of(STATUS_OK, 0, 0, 0, 0, 0, 0)));
      stim_table.push_back(cap_row(1));
      stim_table.push_back(checked_row(ACT_CREATE, 0, 0, rsp_of(STATUS_OK, 0, 1, 0, 1, 1, 1)));
      stim_table.push_back(checked_row(ACT_CREATE, 0, 1, rsp_of(STATUS_NOFREE, 0, 0, 1, 1, 1, 1)));
      stim_table.push_back(checked_row(ACT_DESTROY, 0, 1, rsp_of(STATUS_OK, 0, 0, 1, 0, 1, 1)));
      stim_table.push_back(cmd_row(ACT_CLEAR, 0, 0));
      stim_table.push_back(cmd_row(ACT_CREATE, 0, 0));

      foreach (stim_table[r]) begin
         if (stim_table[r].kind == ROW_CAP)
            write_capacity(stim_table[r].cap);
         else
            send_command(stim_table[r].cmd, stim_table[r].has_want, stim_table[r].want);
      end

      // Random phases over capacities and idling mixes
      phase_cap   = '{8, 16, 5, 1024, 2, 64};
      phase_idle  = '{0, 78, 0, 8, 78, 0};
      phase_stall = '{0, 0, 78, 8, 0, 78};
      for (int p = 0; p < 6; p++) begin
         write_capacity(CAP_W'(phase_cap[p]));
         send_idle_pct = phase_idle[p];
         rsp_stall_pct = phase_stall[p];
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if ($urandom_range(0, 99) < 2)
               wait_idle();
            send_command(random_cmd(), 1'b0, no_rsp);
         end
      end

      // Drain and let the pipeline settle
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d commands (%0d create, %0d destroy, %0d validate, %0d clear)",
               cmd_count[0] + cmd_count[1] + cmd_count[2] + cmd_count[3],
               cmd_count[ACT_CREATE], cmd_count[ACT_DESTROY], cmd_count[ACT_VALIDATE],
               cmd_count[ACT_CLEAR]);
      $display("%0d responses (%0d no free slot, %0d stale), %0d capacity writes, %0d mismatches",
               rsp_seen, nofree_seen, stale_seen, cap_writes, mismatch_count);
      if (mismatch_count == 0 && pending_rsp.size() == 0)
         $display("generational_handle_allocator_top regression: pass");
      else
         $display("generational_handle_allocator_top regression: fail");
      $finish;
   end

   // Hard stop for a hung handshake
   initial begin
      #80_000_000;
      $display("timeout with %0d responses outstanding", pending_rsp.size());
      $display("generational_handle_allocator_top regression: fail");
      $finish;
   end

endmodule
